// ===== rtl/wrf_pkg.sv =====
package wrf_pkg;

  localparam int unsigned PIX_W     = 8;
  localparam int unsigned WIN_SIDE  = 3;
  localparam int unsigned WIN_COUNT = WIN_SIDE * WIN_SIDE;
  localparam int unsigned CENTRE_IDX = WIN_COUNT / 2;

  typedef logic [PIX_W-1:0] pixel_t;

  typedef enum logic [1:0] {
    MODE_MIN      = 2'd0,
    MODE_MAX      = 2'd1,
    MODE_MEDIAN   = 2'd2,
    MODE_ADAPTIVE = 2'd3
  } filter_mode_t;

endpackage

// ===== rtl/wrf_ifs.sv =====
// Window channel: one complete 3x3 window per word.
interface wrf_win_if;
  import wrf_pkg::*;

  logic   valid;
  logic   ready;
  pixel_t pix_top_left;
  pixel_t pix_top_mid;
  pixel_t pix_top_right;
  pixel_t pix_mid_left;
  pixel_t pix_centre;
  pixel_t pix_mid_right;
  pixel_t pix_bot_left;
  pixel_t pix_bot_mid;
  pixel_t pix_bot_right;

  modport source (
    output valid, pix_top_left, pix_top_mid, pix_top_right, pix_mid_left, pix_centre,
           pix_mid_right, pix_bot_left, pix_bot_mid, pix_bot_right,
    input  ready
  );

  modport sink (
    input  valid, pix_top_left, pix_top_mid, pix_top_right, pix_mid_left, pix_centre,
           pix_mid_right, pix_bot_left, pix_bot_mid, pix_bot_right,
    output ready
  );
endinterface

// Result channel: one filtered pixel per word.
interface wrf_pix_if;
  import wrf_pkg::*;

  logic   valid;
  logic   ready;
  pixel_t out_pixel;

  modport source (output valid, out_pixel, input ready);
  modport sink (input valid, out_pixel, output ready);
endinterface

// Mode register write channel.
interface wrf_cfg_if;
  import wrf_pkg::*;

  logic         valid;
  logic         ready;
  filter_mode_t filter_mode;

  modport source (output valid, filter_mode, input ready);
  modport sink (input valid, filter_mode, output ready);
endinterface

// ===== rtl/window_rank_filter_3x3.sv =====
// Data path: an accepted window is held in the input register, then moves on to the result
// register, from which it is offered as a result; a stall at the output can hold it there.
// Throughput: one window per cycle while results are taken; a result left waiting at
// the output register lets the input register take one more word, then input stalls.
// Reset (synchronous, rst_n low) empties both stages and sets the mode to median.
module window_rank_filter_3x3 (
  input logic        clk,
  input logic        rst_n,
  wrf_win_if.sink    in_win,
  wrf_pix_if.source  out_pix,
  wrf_cfg_if.sink    cfg_mode
);
  import wrf_pkg::*;

  function automatic pixel_t min2(input pixel_t a, input pixel_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic pixel_t max2(input pixel_t a, input pixel_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic pixel_t med3(input pixel_t a, input pixel_t b, input pixel_t c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  filter_mode_t mode_r;

  logic   s1_valid_r;
  pixel_t win_r [WIN_COUNT];
  logic   out_valid_r;
  pixel_t out_pixel_r;

  logic   s1_adv;
  logic   in_accept;
  pixel_t row_lo  [WIN_SIDE];
  pixel_t row_mid [WIN_SIDE];
  pixel_t row_hi  [WIN_SIDE];
  pixel_t win_min;
  pixel_t win_max;
  pixel_t win_med;
  pixel_t centre;
  pixel_t out_pixel_nxt;

  // Stage one moves forward whenever the result register is empty or being drained.
  assign s1_adv    = !out_valid_r || out_pix.ready;
  assign in_win.ready = !s1_valid_r || s1_adv;
  assign in_accept = in_win.valid && in_win.ready;

  assign cfg_mode.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_MEDIAN;
    end else if (cfg_mode.valid) begin
      mode_r <= cfg_mode.filter_mode;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_win.ready) begin
      s1_valid_r <= in_win.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      win_r[0] <= in_win.pix_top_left;
      win_r[1] <= in_win.pix_top_mid;
      win_r[2] <= in_win.pix_top_right;
      win_r[3] <= in_win.pix_mid_left;
      win_r[4] <= in_win.pix_centre;
      win_r[5] <= in_win.pix_mid_right;
      win_r[6] <= in_win.pix_bot_left;
      win_r[7] <= in_win.pix_bot_mid;
      win_r[8] <= in_win.pix_bot_right;
    end
  end

  // Sort each row, then the median of the window is the median of the largest row
  // minimum, the middle row median and the smallest row maximum.
  always_comb begin
    for (int r = 0; r < WIN_SIDE; r++) begin
      row_lo[r]  = min2(min2(win_r[WIN_SIDE*r], win_r[WIN_SIDE*r+1]), win_r[WIN_SIDE*r+2]);
      row_hi[r]  = max2(max2(win_r[WIN_SIDE*r], win_r[WIN_SIDE*r+1]), win_r[WIN_SIDE*r+2]);
      row_mid[r] = med3(win_r[WIN_SIDE*r], win_r[WIN_SIDE*r+1], win_r[WIN_SIDE*r+2]);
    end
    win_min = min2(min2(row_lo[0], row_lo[1]), row_lo[2]);
    win_max = max2(max2(row_hi[0], row_hi[1]), row_hi[2]);
    win_med = med3(max2(max2(row_lo[0], row_lo[1]), row_lo[2]),
                   med3(row_mid[0], row_mid[1], row_mid[2]),
                   min2(min2(row_hi[0], row_hi[1]), row_hi[2]));
    centre  = win_r[CENTRE_IDX];
  end

  always_comb begin
    case (mode_r)
      MODE_MIN:    out_pixel_nxt = win_min;
      MODE_MAX:    out_pixel_nxt = win_max;
      MODE_MEDIAN: out_pixel_nxt = win_med;
      default: begin
        // The centre passes through only if neither it nor the median is an extreme.
        if ((win_min < win_med) && (win_med < win_max) &&
            (win_min < centre) && (centre < win_max)) begin
          out_pixel_nxt = centre;
        end else begin
          out_pixel_nxt = win_med;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid_r) begin
      out_pixel_r <= out_pixel_nxt;
    end
  end

  assign out_pix.valid     = out_valid_r;
  assign out_pix.out_pixel = out_pixel_r;

`ifndef SYNTHESIS
  a_mode_reset: assert property (@(posedge clk) !rst_n |=> mode_r == MODE_MEDIAN)
    else $error("mode register not set to median by reset");

  a_result_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> (out_pixel_nxt >= win_min) && (out_pixel_nxt <= win_max))
    else $error("filtered pixel outside the window range");

  a_median_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> (win_med >= win_min) && (win_med <= win_max))
    else $error("median outside the window range");

  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_win.valid && in_win.ready |=> s1_valid_r)
    else $error("accepted word did not reach the input register");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_valid_r && !out_pix.ready |-> !in_win.ready)
    else $error("input taken while both stages are full and stalled");
`endif

endmodule
